FILE: sv/dtfe_pkg.sv
// Types, codes and calendar helpers shared by the date/time field editor.
package dtfe_pkg;

  localparam int YearW = 14;

  // item kinds
  localparam logic [1:0] KIND_SELECT = 2'd0;
  localparam logic [1:0] KIND_UP     = 2'd1;
  localparam logic [1:0] KIND_DOWN   = 2'd2;
  localparam logic [1:0] KIND_LOAD   = 2'd3;

  // field codes
  localparam logic [2:0] FIELD_YEAR   = 3'd0;
  localparam logic [2:0] FIELD_MONTH  = 3'd1;
  localparam logic [2:0] FIELD_DAY    = 3'd2;
  localparam logic [2:0] FIELD_HOUR   = 3'd3;
  localparam logic [2:0] FIELD_MINUTE = 3'd4;
  localparam logic [2:0] FIELD_SECOND = 3'd5;

  // configuration register indexes
  localparam logic REG_YEAR_FLOOR   = 1'b0;
  localparam logic REG_YEAR_CEILING = 1'b1;

  localparam logic [YearW-1:0] DEFAULT_YEAR  = 14'd2026;
  localparam logic [YearW-1:0] FLOOR_RESET   = 14'd2000;
  localparam logic [YearW-1:0] CEILING_RESET = 14'd2099;
  localparam logic [YearW-1:0] MIN_READ_YEAR = 14'd2000;

  localparam logic [3:0] MONTH_MAX  = 4'd12;
  localparam logic [4:0] HOUR_MAX   = 5'd23;
  localparam logic [5:0] MINSEC_MAX = 6'd59;
  localparam logic [2:0] WEEKDAY_MAX = 3'd6;

  // multiplicative inverse of 25 modulo 2^14 and the divisibility threshold
  localparam logic [YearW-1:0] INV25     = 14'd7209;
  localparam logic [YearW-1:0] DIV25_LIM = 14'd655;

  typedef struct packed {
    logic [1:0]       kind;
    logic [2:0]       field_index;
    logic             clock_present;
    logic [YearW-1:0] read_year;
    logic [3:0]       read_month;
    logic [4:0]       read_day;
    logic [2:0]       read_weekday;
    logic [4:0]       read_hour;
    logic [5:0]       read_minute;
    logic [5:0]       read_second;
  } item_t;

  typedef struct packed {
    logic [YearW-1:0] cur_year;
    logic [3:0]       cur_month;
    logic [4:0]       cur_day;
    logic [4:0]       cur_hour;
    logic [5:0]       cur_minute;
    logic [5:0]       cur_second;
    logic [2:0]       cur_selection;
    logic             used_default;
  } result_t;

  typedef struct packed {
    logic [YearW-1:0] year;
    logic [3:0]       month;
    logic [4:0]       day;
    logic [4:0]       hour;
    logic [5:0]       minute;
    logic [5:0]       second;
    logic [2:0]       selection;
  } edit_t;

  localparam edit_t EDIT_RESET = '{year: DEFAULT_YEAR, month: 4'd1, day: 5'd1,
                                   hour: 5'd0, minute: 6'd0, second: 6'd0,
                                   selection: FIELD_YEAR};

  // Gregorian leap test; divisibility by 25 via the odd-inverse trick
  function automatic logic leap(input logic [YearW-1:0] y);
    logic [YearW-1:0] p;
    logic             div25;
    p     = y * INV25;
    div25 = (p <= DIV25_LIM);
    return ((y[1:0] == 2'b00) && !div25) || ((y[3:0] == 4'b0000) && div25);
  endfunction

  function automatic logic [4:0] month_length(input logic [YearW-1:0] y,
                                              input logic [3:0] m);
    logic [4:0] len;
    unique case (m)
      4'd2:                      len = leap(y) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

FILE: sv/dtfe_calc.sv
// Next-state and result logic for one item of the date/time field editor.
module dtfe_calc (
  input  dtfe_pkg::item_t            item,
  input  dtfe_pkg::edit_t            edit,
  input  logic [dtfe_pkg::YearW-1:0] year_floor,
  input  logic [dtfe_pkg::YearW-1:0] year_ceiling,
  output dtfe_pkg::edit_t            edit_next,
  output dtfe_pkg::result_t          result
);
  import dtfe_pkg::*;

  logic              down;
  logic signed [15:0] year_step;
  logic [YearW-1:0]  year_w;
  logic [4:0]        month_step;
  logic [3:0]        month_w;
  logic [4:0]        lim_now;
  logic [5:0]        day_step;
  logic [4:0]        day_w;
  logic [4:0]        hour_w;
  logic [5:0]        minute_w;
  logic [5:0]        second_w;
  edit_t             stepped;
  logic [4:0]        lim_new;
  logic              read_ok;
  logic              fallback;

  assign down = (item.kind == KIND_DOWN);

  always_comb begin
    year_step = down ? (signed'({2'b00, edit.year}) - 16'sd1)
                     : (signed'({2'b00, edit.year}) + 16'sd1);
    // lower bound checked first, as with an inverted range
    if (year_step < signed'({2'b00, year_floor})) begin
      year_w = year_ceiling;
    end else if (year_step > signed'({2'b00, year_ceiling})) begin
      year_w = year_floor;
    end else begin
      year_w = year_step[YearW-1:0];
    end

    month_step = down ? ({1'b0, edit.month} - 5'd1) : ({1'b0, edit.month} + 5'd1);
    if (down && edit.month <= 4'd1) begin
      month_w = MONTH_MAX;
    end else if (!down && month_step > {1'b0, MONTH_MAX}) begin
      month_w = 4'd1;
    end else begin
      month_w = month_step[3:0];
    end

    // a day past month's end wraps to 1 if its step stays past the end
    lim_now  = month_length(edit.year, edit.month);
    day_step = down ? ({1'b0, edit.day} - 6'd1) : ({1'b0, edit.day} + 6'd1);
    if (down && edit.day <= 5'd1) begin
      day_w = lim_now;
    end else if (day_step > {1'b0, lim_now}) begin
      day_w = 5'd1;
    end else begin
      day_w = day_step[4:0];
    end

    if (down) begin
      hour_w   = (edit.hour == 5'd0) ? HOUR_MAX : edit.hour - 5'd1;
      minute_w = (edit.minute == 6'd0) ? MINSEC_MAX : edit.minute - 6'd1;
      second_w = (edit.second == 6'd0) ? MINSEC_MAX : edit.second - 6'd1;
    end else begin
      hour_w   = (edit.hour >= HOUR_MAX) ? 5'd0 : edit.hour + 5'd1;
      minute_w = (edit.minute >= MINSEC_MAX) ? 6'd0 : edit.minute + 6'd1;
      second_w = (edit.second >= MINSEC_MAX) ? 6'd0 : edit.second + 6'd1;
    end

    stepped = edit;
    unique case (edit.selection)
      FIELD_YEAR:   stepped.year   = year_w;
      FIELD_MONTH:  stepped.month  = month_w;
      FIELD_DAY:    stepped.day    = day_w;
      FIELD_HOUR:   stepped.hour   = hour_w;
      FIELD_MINUTE: stepped.minute = minute_w;
      default:      stepped.second = second_w;
    endcase
    // day is clamped to the month after any step
    lim_new = month_length(stepped.year, stepped.month);
    if (stepped.day > lim_new) begin
      stepped.day = lim_new;
    end
  end

  assign read_ok = item.clock_present
                && (item.read_year >= MIN_READ_YEAR)
                && (item.read_month >= 4'd1) && (item.read_month <= MONTH_MAX)
                && (item.read_day >= 5'd1)
                && (item.read_weekday <= WEEKDAY_MAX)
                && (item.read_hour <= HOUR_MAX)
                && (item.read_minute <= MINSEC_MAX)
                && (item.read_second <= MINSEC_MAX);

  always_comb begin
    edit_next = edit;
    fallback  = 1'b0;
    unique case (item.kind)
      KIND_SELECT: begin
        if (item.field_index <= FIELD_SECOND) begin
          edit_next.selection = item.field_index;
        end
      end
      KIND_UP, KIND_DOWN: begin
        edit_next = stepped;
      end
      default: begin
        if (read_ok) begin
          edit_next.year   = item.read_year;
          edit_next.month  = item.read_month;
          edit_next.day    = item.read_day;
          edit_next.hour   = item.read_hour;
          edit_next.minute = item.read_minute;
          edit_next.second = item.read_second;
        end else begin
          edit_next = EDIT_RESET;
          fallback  = 1'b1;
        end
        edit_next.selection = FIELD_YEAR;
      end
    endcase
  end

  assign result = '{cur_year: edit_next.year, cur_month: edit_next.month,
                    cur_day: edit_next.day, cur_hour: edit_next.hour,
                    cur_minute: edit_next.minute, cur_second: edit_next.second,
                    cur_selection: edit_next.selection, used_default: fallback};

endmodule

FILE: sv/date_time_field_editor.sv
// Top level of the date/time field editor: item register, edit state, result register.
//
//   channel  direction  handshake                  payload
//   item     in         item_valid/item_stall      item (item_t)
//   result   out        result_valid/result_stall  result (result_t)
//   cfg      in         cfg_valid/cfg_ready        cfg_index, cfg_data
//
// One item per cycle sustained while the result is not stalled; an item is held in
// the item register and passes through the combinational edit logic into the result
// register.
// Synchronous reset restores 2026-01-01 00:00:00, year selected, bounds 2000..2099.
// A stalled result holds; the item register still takes one more transaction.
module date_time_field_editor (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  dtfe_pkg::item_t            item,
  output logic                       result_valid,
  input  logic                       result_stall,
  output dtfe_pkg::result_t          result,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic [dtfe_pkg::YearW-1:0] cfg_data
);
  import dtfe_pkg::*;

  item_t            item_q;
  logic             item_full;
  edit_t            edit;
  edit_t            edit_next;
  result_t          result_next;
  logic [YearW-1:0] year_floor;
  logic [YearW-1:0] year_ceiling;
  logic             out_free;
  logic             fire;
  logic             take;

  assign out_free   = !result_valid || !result_stall;
  assign fire       = item_full && out_free;
  assign item_stall = item_full && !out_free;
  assign take       = item_valid && !item_stall;
  assign cfg_ready  = 1'b1;

  dtfe_calc u_calc (
    .item         (item_q),
    .edit         (edit),
    .year_floor   (year_floor),
    .year_ceiling (year_ceiling),
    .edit_next    (edit_next),
    .result       (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_full    <= 1'b0;
      result_valid <= 1'b0;
      edit         <= EDIT_RESET;
      year_floor   <= FLOOR_RESET;
      year_ceiling <= CEILING_RESET;
    end else begin
      if (take) begin
        item_full <= 1'b1;
      end else if (fire) begin
        item_full <= 1'b0;
      end
      if (fire) begin
        result_valid <= 1'b1;
        edit         <= edit_next;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_YEAR_FLOOR:   year_floor   <= cfg_data;
          REG_YEAR_CEILING: year_ceiling <= cfg_data;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_q <= item;
    end
    if (fire) begin
      result <= result_next;
    end
  end

endmodule

FILE: sv/dtfe_checker.sv
// Port-level assertions for the date/time field editor, bound to the top level.
module dtfe_checker (
  input logic              clk,
  input logic              rst,
  input logic              result_valid,
  input logic              result_stall,
  input dtfe_pkg::result_t result
);
  import dtfe_pkg::*;

  // no result straight after reset
  a_reset_empty: assert property (@(posedge clk) !rst && $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result transaction changed");

  a_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.cur_month >= 4'd1 && result.cur_month <= MONTH_MAX
                  && result.cur_day >= 5'd1 && result.cur_hour <= HOUR_MAX
                  && result.cur_minute <= MINSEC_MAX && result.cur_second <= MINSEC_MAX
                  && result.cur_selection <= FIELD_SECOND)
    else $error("edited value out of range");

  a_default: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.used_default |-> result.cur_year == DEFAULT_YEAR
                  && result.cur_month == 4'd1 && result.cur_day == 5'd1
                  && result.cur_hour == 5'd0 && result.cur_minute == 6'd0
                  && result.cur_second == 6'd0 && result.cur_selection == FIELD_YEAR)
    else $error("fallback result is not the default date");

endmodule

bind date_time_field_editor dtfe_checker u_checker (.*);
